/* design/tlpt_pkg.sv */
`default_nettype none
package tlpt_pkg;

  localparam int DIR_ENTRIES = 1024;
  localparam int IDX_W       = 10;
  localparam int OFF_W       = 12;
  localparam int PAGE_W      = 20;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_IDMAP = 2'd1,
    CMD_UNMAP = 2'd2,
    CMD_XLATE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_NO_TABLE    = 3'd1,
    STAT_NOT_PRESENT = 3'd2,
    STAT_OUT_OF_TBL  = 3'd3,
    STAT_ALREADY     = 3'd4
  } pt_status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_PTE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic alloc;
    logic fail;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_done;
    logic dir_present;
    logic want_alloc;
    logic room;
  } dp_status_t;

endpackage
`default_nettype wire

/* design/tlpt_ctrl.sv */
`default_nettype none
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t dp_st,
  output ctrl_cmd_t       cmd,
  output logic            busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (dp_st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DIR;
        end
      end
      S_DIR: begin
        priority if (dp_st.dir_present) begin
          state_next = S_PTE;
        end else if (dp_st.want_alloc && dp_st.room) begin
          cmd.alloc  = 1'b1;
          state_next = S_PTE;
        end else begin
          cmd.fail   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PTE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/tlpt_datapath.sv */
`default_nettype none
module tlpt_datapath
  import tlpt_pkg::*;
#(
  parameter int TABLE_POOL = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  output dp_status_t       dp_st,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] virtual_address,
  input  wire logic [19:0] physical_frame,
  input  wire logic [11:0] entry_flags,
  input  wire logic        cfg_valid,
  input  wire logic [4:0]  cfg_data,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      physical_address,
  output logic             flush_valid,
  output logic [31:0]      flush_address
);

  localparam int TW    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int DW    = $clog2(TABLE_POOL + 1);
  localparam int TA    = TW + IDX_W;
  localparam int DEPTH = TABLE_POOL * DIR_ENTRIES;
  localparam int CW    = (DW > 5) ? DW : 5;

  logic [DW-1:0] dir_mem [DIR_ENTRIES];
  logic [31:0]   tbl_mem [DEPTH];

  logic [4:0]       table_limit;
  logic [DW-1:0]    next_table;
  logic [TA-1:0]    clr_addr;
  cmd_t             cmd_r;
  logic [31:0]      va_r;
  logic [19:0]      frame_r;
  logic [11:0]      flags_r;
  logic [DW-1:0]    dir_rdata;
  logic [31:0]      pte_rdata;
  logic [TA-1:0]    pte_addr;

  logic [IDX_W-1:0] dir_raddr;
  logic [DW-1:0]    tab_full;
  logic [TW-1:0]    tab_idx;
  logic [TA-1:0]    tbl_raddr;
  logic [CW-1:0]    limit_eff;
  logic             pte_we;
  logic [31:0]      pte_wdata;
  pt_status_t       pte_stat;
  logic [31:0]      pte_phys;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= 5'd16;
    end else if (cfg_valid) begin
      table_limit <= cfg_data;
    end
  end

  // The reset pass zeroes every table, so a freshly allocated table needs no
  // clearing of its own: tables are handed out once and never returned.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_table <= '0;
    end else if (cmd.alloc) begin
      next_table <= next_table + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= cmd_t'(command);
      va_r    <= virtual_address;
      frame_r <= physical_frame;
      flags_r <= entry_flags;
    end
  end

  assign dir_raddr = cmd.capture ? virtual_address[31:22] : va_r[31:22];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      dir_mem[clr_addr[IDX_W-1:0]] <= '0;
    end else if (cmd.alloc) begin
      dir_mem[va_r[31:22]] <= DW'(next_table + 1'b1);
    end
    dir_rdata <= dir_mem[dir_raddr];
  end

  assign tab_full  = dir_rdata - 1'b1;
  assign tab_idx   = cmd.alloc ? next_table[TW-1:0] : tab_full[TW-1:0];
  assign tbl_raddr = {tab_idx, va_r[21:12]};

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tbl_mem[clr_addr] <= '0;
    end else if (cmd.finish && pte_we) begin
      tbl_mem[pte_addr] <= pte_wdata;
    end
    pte_rdata <= tbl_mem[tbl_raddr];
    pte_addr  <= tbl_raddr;
  end

  assign limit_eff = (CW'(table_limit) < CW'(TABLE_POOL)) ? CW'(table_limit)
                                                          : CW'(TABLE_POOL);

  assign dp_st.clear_done  = (clr_addr == TA'(DEPTH - 1));
  assign dp_st.dir_present = (dir_rdata != '0);
  assign dp_st.want_alloc  = (cmd_r == CMD_MAP) || (cmd_r == CMD_IDMAP);
  assign dp_st.room        = (CW'(next_table) < limit_eff);

  always_comb begin
    pte_we    = 1'b0;
    pte_wdata = '0;
    pte_stat  = STAT_OK;
    pte_phys  = '0;
    unique case (cmd_r)
      CMD_MAP: begin
        pte_we    = 1'b1;
        pte_wdata = {frame_r, flags_r[11:1], 1'b1};
      end
      CMD_IDMAP: begin
        if (pte_rdata[0]) begin
          pte_stat = STAT_ALREADY;
        end else begin
          pte_we    = 1'b1;
          pte_wdata = {va_r[31:12], 10'd0, 2'b11};
        end
      end
      CMD_UNMAP: begin
        pte_we = 1'b1;
      end
      CMD_XLATE: begin
        if (pte_rdata[0]) begin
          pte_phys = {pte_rdata[31:12], va_r[11:0]};
        end else begin
          pte_stat = STAT_NOT_PRESENT;
        end
      end
      default: begin
        pte_stat = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish || cmd.fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      status           <= dp_st.want_alloc ? STAT_OUT_OF_TBL : STAT_NO_TABLE;
      physical_address <= '0;
      flush_valid      <= 1'b0;
      flush_address    <= '0;
    end else if (cmd.finish) begin
      status           <= pte_stat;
      physical_address <= pte_phys;
      flush_valid      <= pte_we;
      flush_address    <= pte_we ? {va_r[31:12], 12'd0} : 32'd0;
    end
  end

endmodule
`default_nettype wire

/* design/two_level_page_table_manager_unit.sv */
// Two-level page table manager: one 1024-entry directory whose entries point
// to tables of 1024 page entries drawn from a pool of TABLE_POOL tables.
// Request channel: drive command, virtual_address, physical_frame and
// entry_flags with start; the word is taken at a clock edge where start is
// high and busy is low. Commands are map, identity map, unmap and translate.
// Result channel: done is high for exactly one cycle with status,
// physical_address, flush_valid and flush_address. The receiver cannot stall;
// a result must be taken in the cycle it is shown.
// Sequence: the directory is read, then the table; done rises on the edge
// that lands the table write-back, or after the directory read alone when
// no table is present or none can be allocated. busy drops together with
// done, so the next word can be taken at the edge that ends the result
// cycle; a new request is not taken while one is in flight.
// Configuration: cfg_data writes table_limit when cfg_valid is high; cfg_ready
// is always high. Write it only while the block is idle.
// Reset: rst is synchronous. After reset the block runs a clearing pass
// with busy high, zeroing every table entry and directory slot; table_limit
// resets to 16.
`default_nettype none
module two_level_page_table_manager_unit
  import tlpt_pkg::*;
#(
  parameter int TABLE_POOL = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] virtual_address,
  input  wire logic [19:0] physical_frame,
  input  wire logic [11:0] entry_flags,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      physical_address,
  output logic             flush_valid,
  output logic [31:0]      flush_address,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  assign cfg_ready = 1'b1;

  tlpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .dp_st (dp_st),
    .cmd   (cmd),
    .busy  (busy)
  );

  tlpt_datapath #(
    .TABLE_POOL (TABLE_POOL)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .dp_st            (dp_st),
    .command          (command),
    .virtual_address  (virtual_address),
    .physical_frame   (physical_frame),
    .entry_flags      (entry_flags),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .done             (done),
    .status           (status),
    .physical_address (physical_address),
    .flush_valid      (flush_valid),
    .flush_address    (flush_address)
  );

  // A result only ever closes a request that was in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    (done && flush_valid) |-> (status == STAT_OK))
    else $error("flush reported on a failed request");

  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (physical_address == '0 && !flush_valid))
    else $error("failed request returned an address or a flush");

endmodule
`default_nettype wire
